// File: hw/rtl/jddp_pkg.sv
// Package for the joystick differential-drive PWM block.
// Holds shared constants, register indexes, the result word layout and the wheel job type.
// It depends on nothing else.
package jddp_pkg;

    localparam int JOY_BITS_DEF = 8;

    // configuration register indexes
    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_MIN_DUTY   = 2'd1;
    localparam logic [1:0] REG_PERIOD     = 2'd2;

    localparam logic [7:0]  FULL_SCALE_RST = 8'd50;
    localparam logic [6:0]  MIN_DUTY_RST   = 7'd65;
    localparam logic [15:0] PERIOD_RST     = 16'd2000;
    localparam logic [6:0]  LEVEL_FULL     = 7'd100;

    // result word fields
    typedef struct packed {
        logic [6:0] right_level;
        logic [6:0] left_level;
        logic       right_reverse;
        logic       left_reverse;
        logic       right_pin;
        logic       left_pin;
    } result_t;

    // one wheel job handed to the serial duty unit
    typedef struct packed {
        logic        unit;
        logic        neg;
    } wheel_job_t;

endpackage

// File: hw/rtl/joystick_differential_drive_pwm.sv
// Joystick differential-drive mixer with two PWM channels; uses jddp_pkg, jddp_root, jddp_duty.
// A tick gives its result word in the cycle after acceptance; an update passes through the
// squaring state, the bit-serial root, two wheel passes (serial multiply and divide) and the
// output state before its result word is given.
// Throughput: one word at a time; the next word is taken once the result word has left.
// Reset (aresetn low, synchronous) loads register defaults, counter 0, compares 100, pins, dirs low.
module joystick_differential_drive_pwm #(
    parameter int JOY_BITS = jddp_pkg::JOY_BITS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // tdata: joy_x, joy_y (lowest first), zero padded to bytes
    input  logic [((2*JOY_BITS+7)/8)*8-1:0] s_tdata,
    // tuser: command
    input  logic                      s_tuser,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // tdata: left_pin, right_pin, left_reverse, right_reverse, left_level, right_level
    output logic [23:0]               m_tdata,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data
);
    localparam int SW = 2 * JOY_BITS;        // width of x*x + y*y (needs +1)
    localparam int RW = JOY_BITS + 9;        // root of s<<16
    localparam int NW = SW + 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQ    = 3'd1;
    localparam logic [2:0] ST_ROOT  = 3'd2;
    localparam logic [2:0] ST_LEFT  = 3'd3;
    localparam logic [2:0] ST_RIGHT = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    // quadrant sectors
    localparam logic [1:0] SEC_UP_RIGHT   = 2'd0;
    localparam logic [1:0] SEC_UP_LEFT    = 2'd1;
    localparam logic [1:0] SEC_DOWN_RIGHT = 2'd2;
    localparam logic [1:0] SEC_DOWN_LEFT  = 2'd3;

    logic [7:0]  fs_reg;
    logic [6:0]  md_reg;
    logic [15:0] period_reg;
    logic [15:0] cnt_reg;
    logic [6:0]  lcmp_reg, rcmp_reg;
    logic        lout_reg, rout_reg, ldir_reg, rdir_reg;
    logic [2:0]  state_reg;
    logic        go_reg;

    logic signed [JOY_BITS-1:0] x_reg, y_reg;
    logic [SW-1:0]  xx_reg, yy_reg;
    logic [NW-1:0]  s_sum, c_num, c_den;
    logic           c_neg;
    logic           wheel_neg;
    logic [1:0]     sector_reg;
    jddp_pkg::wheel_job_t ljob, rjob, job;
    logic [RW-1:0]  root;
    logic           root_done, duty_done;
    logic [6:0]     add, md_eff, span, level;
    logic [15:0]    cnt_inc;
    logic           accept;
    jddp_pkg::result_t res;

    assign s_tready  = (state_reg == ST_IDLE) && !m_tvalid;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;

    // sector flags per wheel
    always_comb begin
        case (sector_reg)
            SEC_UP_RIGHT: begin ljob = '{1'b1, 1'b0}; rjob = '{1'b0, 1'b1}; end
            SEC_UP_LEFT:  begin ljob = '{1'b0, 1'b1}; rjob = '{1'b1, 1'b0}; end
            SEC_DOWN_RIGHT: begin ljob = '{1'b0, 1'b0}; rjob = '{1'b1, 1'b1}; end
            default:      begin ljob = '{1'b1, 1'b1}; rjob = '{1'b0, 1'b0}; end
        endcase
    end
    assign job    = (state_reg == ST_RIGHT) ? rjob : ljob;
    assign md_eff = (md_reg > jddp_pkg::LEVEL_FULL) ? jddp_pkg::LEVEL_FULL : md_reg;
    assign span   = jddp_pkg::LEVEL_FULL - md_eff;
    assign level  = md_eff + add;
    assign cnt_inc = cnt_reg + 16'd1;

    jddp_root #(.IN_BITS(NW + 16), .OUT_BITS(RW)) u_root (
        .aclk(aclk), .aresetn(aresetn),
        .start(go_reg && state_reg == ST_ROOT),
        .radicand({s_sum, 16'd0}), .done(root_done), .root(root)
    );

    jddp_duty #(.RW(RW), .NW(NW)) u_duty (
        .aclk(aclk), .aresetn(aresetn),
        .start(go_reg && (state_reg == ST_LEFT || state_reg == ST_RIGHT)),
        .r(root),
        .n(job.unit ? NW'(1) : c_num),
        .d(job.unit ? NW'(1) : c_den),
        .fs(fs_reg), .span(span), .done(duty_done), .add(add)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fs_reg     <= jddp_pkg::FULL_SCALE_RST;
            md_reg     <= jddp_pkg::MIN_DUTY_RST;
            period_reg <= jddp_pkg::PERIOD_RST;
            cnt_reg    <= '0;
            lcmp_reg   <= jddp_pkg::LEVEL_FULL;
            rcmp_reg   <= jddp_pkg::LEVEL_FULL;
            lout_reg   <= 1'b0;
            rout_reg   <= 1'b0;
            ldir_reg   <= 1'b0;
            rdir_reg   <= 1'b0;
            state_reg  <= ST_IDLE;
            go_reg     <= 1'b0;
            m_tvalid   <= 1'b0;
        end else begin
            go_reg <= 1'b0;
            if (m_tvalid && m_tready)
                m_tvalid <= 1'b0;
            // register writes
            if (cfg_valid) begin
                case (cfg_index)
                    jddp_pkg::REG_FULL_SCALE: fs_reg     <= cfg_data[7:0];
                    jddp_pkg::REG_MIN_DUTY:   md_reg     <= cfg_data[6:0];
                    jddp_pkg::REG_PERIOD:     period_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_tuser) begin
                            x_reg     <= s_tdata[JOY_BITS-1:0];
                            y_reg     <= s_tdata[2*JOY_BITS-1:JOY_BITS];
                            state_reg <= ST_SQ;
                        end else begin
                            // pwm tick
                            if ({16'd0, cnt_inc} > {16'd0, period_reg}) begin
                                cnt_reg  <= '0;
                                lout_reg <= 1'b1;
                                rout_reg <= 1'b1;
                            end else begin
                                cnt_reg  <= cnt_inc;
                                lout_reg <= {9'd0, lcmp_reg} > cnt_inc;
                                rout_reg <= {9'd0, rcmp_reg} > cnt_inc;
                            end
                            m_tvalid <= 1'b1;
                        end
                    end
                end
                ST_SQ: begin
                    xx_reg    <= SW'(x_reg * x_reg);
                    yy_reg    <= SW'(y_reg * y_reg);
                    if (y_reg > 0 && x_reg >= 0)       sector_reg <= SEC_UP_RIGHT;
                    else if (x_reg < 0 && y_reg >= 0)  sector_reg <= SEC_UP_LEFT;
                    else if (y_reg < 0 && x_reg <= 0)  sector_reg <= SEC_DOWN_LEFT;
                    else                               sector_reg <= SEC_DOWN_RIGHT;
                    state_reg <= ST_ROOT;
                    go_reg    <= 1'b1;
                end
                ST_ROOT: begin
                    if (root_done) begin
                        state_reg <= ST_LEFT;
                        go_reg    <= 1'b1;
                    end
                end
                ST_LEFT, ST_RIGHT: begin
                    if (duty_done) begin
                        if (state_reg == ST_LEFT) begin
                            if (wheel_neg) begin
                                lcmp_reg <= jddp_pkg::LEVEL_FULL - level;
                                ldir_reg <= 1'b1;
                            end else begin
                                lcmp_reg <= level;
                                ldir_reg <= 1'b0;
                            end
                            state_reg <= ST_RIGHT;
                            go_reg    <= 1'b1;
                        end else begin
                            if (wheel_neg) begin
                                rcmp_reg <= jddp_pkg::LEVEL_FULL - level;
                                rdir_reg <= 1'b1;
                            end else begin
                                rcmp_reg <= level;
                                rdir_reg <= 1'b0;
                            end
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_OUT: begin
                    m_tvalid  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // cos 2 theta numerator and denominator; a centred stick takes c = 1
    assign s_sum = NW'(xx_reg) + NW'(yy_reg);
    always_comb begin
        c_neg = xx_reg < yy_reg;
        if (s_sum == '0) begin
            c_num = NW'(1);
            c_den = NW'(1);
        end else begin
            c_den = s_sum;
            c_num = c_neg ? NW'(yy_reg - xx_reg) : NW'(xx_reg - yy_reg);
        end
    end

    // combine sign of c with the sector negate flag; a zero c counts as forward
    assign wheel_neg = job.unit ? job.neg : ((c_num != '0) && (job.neg != c_neg));

    assign res.left_pin      = lout_reg;
    assign res.right_pin     = rout_reg;
    assign res.left_reverse  = ldir_reg;
    assign res.right_reverse = rdir_reg;
    assign res.left_level    = lcmp_reg;
    assign res.right_level   = rcmp_reg;
    assign m_tdata = {6'd0, res.right_level, res.left_level, res.right_reverse,
                      res.left_reverse, res.right_pin, res.left_pin};
endmodule

// File: hw/rtl/jddp_root.sv
// Bit-serial integer square root: one result bit per cycle.
// Self-contained; depends on no package and no other module.
module jddp_root #(
    parameter int IN_BITS  = 34,
    parameter int OUT_BITS = 17
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [IN_BITS-1:0]  radicand,
    output logic                done,
    output logic [OUT_BITS-1:0] root
);
    localparam int RB = 2 * OUT_BITS;
    localparam int CW = $clog2(OUT_BITS + 1);

    logic [RB-1:0]       rad_reg;
    logic [OUT_BITS+1:0] rem_reg;
    logic [OUT_BITS-1:0] root_reg;
    logic [CW-1:0]       cnt_reg;
    logic                busy_reg;
    logic [OUT_BITS+1:0] trial;
    logic [OUT_BITS+1:0] rem_sh;

    // shift two radicand bits into the partial remainder each cycle
    assign rem_sh = {rem_reg[OUT_BITS-1:0], rad_reg[RB-1 -: 2]};
    assign trial  = {root_reg, 2'b01};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(OUT_BITS);
                rad_reg  <= RB'(radicand);
                rem_reg  <= '0;
                root_reg <= '0;
            end else if (busy_reg) begin
                rad_reg <= rad_reg << 2;
                if (rem_sh >= trial) begin
                    rem_reg  <= rem_sh - trial;
                    root_reg <= {root_reg[OUT_BITS-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem_sh;
                    root_reg <= {root_reg[OUT_BITS-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign root = root_reg;
endmodule

// File: hw/rtl/jddp_duty.sv
// Serial duty unit: shift-add multiply then restoring divide, one bit a cycle.
// Computes floor(span*r*n / (d*fs*256)) capped at span; depends on no other module.
module jddp_duty #(
    parameter int RW = 17,
    parameter int NW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [RW-1:0] r,
    input  logic [NW-1:0] n,
    input  logic [NW-1:0] d,
    input  logic [7:0]    fs,
    input  logic [6:0]    span,
    output logic          done,
    output logic [6:0]    add
);
    // numerator span*r*n, denominator d*fs*256
    localparam int PW = RW + NW + 7;
    localparam int DW = NW + 8 + 8;
    localparam int CW = $clog2(PW + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [1:0]    state_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] acc_reg;
    logic [PW-1:0] mcand_reg;
    logic [NW+6:0] mplier_reg;
    logic [DW-1:0] div_reg;
    logic [PW-1:0] quo_reg;
    logic [DW:0]   rem_reg;
    logic [DW:0]   rem_sh;
    logic [6:0]    span_reg;
    logic [NW+6:0] sn_full;
    logic [7:0]    fs_eff;

    assign sn_full = (NW + 7)'(n) * (NW + 7)'(span);
    assign rem_sh  = {rem_reg[DW-1:0], acc_reg[PW-1]};
    // a zero full scale acts as one
    assign fs_eff  = (fs == 8'd0) ? 8'd1 : fs;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done      <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        state_reg  <= ST_MUL;
                        acc_reg    <= '0;
                        mcand_reg  <= PW'(r);
                        mplier_reg <= sn_full;
                        div_reg    <= {(NW + 8)'(d) * (NW + 8)'(fs_eff), 8'd0};
                        span_reg   <= span;
                        cnt_reg    <= CW'(NW + 7);
                    end
                end
                // shift-add multiply, one multiplier bit a cycle
                ST_MUL: begin
                    if (mplier_reg[0])
                        acc_reg <= acc_reg + mcand_reg;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= CW'(PW);
                        rem_reg   <= '0;
                        quo_reg   <= '0;
                    end
                end
                // restoring divide, one quotient bit a cycle
                ST_DIV: begin
                    acc_reg <= acc_reg << 1;
                    if (rem_sh >= {1'b0, div_reg}) begin
                        rem_reg <= rem_sh - {1'b0, div_reg};
                        quo_reg <= {quo_reg[PW-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[PW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg - CW'(1);
                    if (cnt_reg == CW'(1)) begin
                        state_reg <= ST_IDLE;
                        done      <= 1'b1;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // cap at span
    assign add = (quo_reg >= PW'(span_reg)) ? span_reg : quo_reg[6:0];
endmodule

// File: dv/tb_joystick_differential_drive_pwm.sv
// Testbench for the joystick differential-drive PWM block: drives ticks and joystick
// updates, predicts every result word and compares it field by field.
// Depends on jddp_pkg and joystick_differential_drive_pwm.
module tb_joystick_differential_drive_pwm;

    localparam int JB = 8;
    localparam int SW = ((2*JB+7)/8)*8;
    // register index with no register behind it
    localparam logic [1:0] REG_UNDEF = 2'd3;

    // predicted drive state and result-word checking
    class drive_scoreboard;
        logic [7:0]  full_scale;
        logic [6:0]  min_duty;
        logic [15:0] period;
        logic [15:0] tick_count;
        logic [6:0]  left_cmp, right_cmp;
        logic        left_out, right_out, left_dir, right_dir;
        jddp_pkg::result_t pending[$];
        int          errors;

        function void reset_state();
            full_scale = jddp_pkg::FULL_SCALE_RST;
            min_duty = jddp_pkg::MIN_DUTY_RST;
            period = jddp_pkg::PERIOD_RST;
            tick_count = 0;
            left_cmp = jddp_pkg::LEVEL_FULL; right_cmp = jddp_pkg::LEVEL_FULL;
            left_out = 0; right_out = 0; left_dir = 0; right_dir = 0;
            pending.delete(); errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            if (idx == jddp_pkg::REG_FULL_SCALE) full_scale = val[7:0];
            else if (idx == jddp_pkg::REG_MIN_DUTY) min_duty = val[6:0];
            else if (idx == jddp_pkg::REG_PERIOD) period = val;
        endfunction

        // integer square root of v
        function longint unsigned isqrt(longint unsigned v);
            longint unsigned res, b;
            res = 0; b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= res + b) begin
                    v -= res + b; res = (res >> 1) + b;
                end else res >>= 1;
                b >>= 2;
            end
            return res;
        endfunction

        // stored compare and direction for one wheel
        function void wheel_duty(longint unsigned r, longint unsigned n, longint unsigned d,
                                 bit neg, output logic [6:0] cmp, output logic dir);
            longint unsigned fs, md, span, dv, add, level;
            fs = full_scale; md = min_duty;
            if (fs == 0) fs = 1;
            if (md > 100) md = 100;
            span = 100 - md;
            dv = d * fs * 256;
            if (r * n >= dv) add = span;
            else add = (span * r * n) / dv;
            if (add > span) add = span;
            level = md + add;
            cmp = neg ? 7'(100 - level) : 7'(level);
            dir = neg;
        endfunction

        function void note_word(bit cmd, logic signed [JB-1:0] x, logic signed [JB-1:0] y);
            jddp_pkg::result_t e;
            longint signed xs, ys;
            longint unsigned xx, yy, s, r, cn, cd;
            bit cneg, lu, ln, ru, rn;
            if (cmd) begin
                xs = x; ys = y; xx = xs*xs; yy = ys*ys; s = xx + yy;
                r = isqrt(s << 16);
                if (s == 0) begin cn = 1; cd = 1; cneg = 0; end
                else begin cneg = xx < yy; cn = cneg ? yy - xx : xx - yy; cd = s; end
                // quadrant sectors
                if (ys > 0 && xs >= 0) begin lu = 1; ln = 0; ru = 0; rn = 1; end
                else if (xs < 0 && ys >= 0) begin lu = 0; ln = 1; ru = 1; rn = 0; end
                else if (ys < 0 && xs <= 0) begin lu = 1; ln = 1; ru = 0; rn = 0; end
                else begin lu = 0; ln = 0; ru = 1; rn = 1; end
                if (lu) wheel_duty(r, 1, 1, ln, left_cmp, left_dir);
                else wheel_duty(r, cn, cd, cn != 0 && (ln != cneg), left_cmp, left_dir);
                if (ru) wheel_duty(r, 1, 1, rn, right_cmp, right_dir);
                else wheel_duty(r, cn, cd, cn != 0 && (rn != cneg), right_cmp, right_dir);
            end else begin
                tick_count = tick_count + 16'd1;
                left_out = left_cmp > tick_count;
                right_out = right_cmp > tick_count;
                if (tick_count > period) begin
                    tick_count = 0; left_out = 1; right_out = 1;
                end
            end
            e.left_pin = left_out; e.right_pin = right_out;
            e.left_reverse = left_dir; e.right_reverse = right_dir;
            e.left_level = left_cmp; e.right_level = right_cmp;
            pending.push_back(e);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_word(logic [23:0] data);
            jddp_pkg::result_t g, e;
            g = data[$bits(jddp_pkg::result_t)-1:0];
            if (pending.size() == 0) begin
                report("unexpected word", data, 0);
                return;
            end
            e = pending.pop_front();
            if (g.left_pin !== e.left_pin) report("left_pin", g.left_pin, e.left_pin);
            if (g.right_pin !== e.right_pin) report("right_pin", g.right_pin, e.right_pin);
            if (g.left_reverse !== e.left_reverse)
                report("left_reverse", g.left_reverse, e.left_reverse);
            if (g.right_reverse !== e.right_reverse)
                report("right_reverse", g.right_reverse, e.right_reverse);
            if (g.left_level !== e.left_level)
                report("left_level", g.left_level, e.left_level);
            if (g.right_level !== e.right_level)
                report("right_level", g.right_level, e.right_level);
            if (data[23:$bits(jddp_pkg::result_t)] !== '0) report("padding", data, 0);
        endtask
    endclass

    logic aclk = 0, aresetn = 0;
    logic s_tvalid = 0, s_tuser = 0, m_tready = 0, cfg_valid = 0;
    logic [SW-1:0] s_tdata = '0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic s_tready, m_tvalid, cfg_ready;
    logic [23:0] m_tdata;
    logic stall_on = 1;

    drive_scoreboard drive_sb;

    joystick_differential_drive_pwm #(.JOY_BITS(JB)) u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5 aclk = ~aclk;

    // receiver stall pattern and result checking
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) drive_sb.check_word(m_tdata);
        m_tready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end

    // one register write while the block is idle
    task write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        drive_sb.write_reg(idx, val);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // send one word and predict it at acceptance; tvalid stays high afterwards
    task send_word(bit cmd, logic [JB-1:0] x, logic [JB-1:0] y);
        s_tvalid <= 1; s_tuser <= cmd; s_tdata <= {y, x};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        drive_sb.note_word(cmd, x, y);
    endtask

    // gap between bursts
    task idle_input(int gap);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // wait until all results are in, plus the update latency
    task drain();
        while (drive_sb.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // random burst traffic; updates are a minority of the words
    task random_traffic(int count, int upd_pct);
        int burst;
        bit cmd;
        while (count > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && count > 0) begin
                cmd = $urandom_range(0, 99) < upd_pct;
                send_word(cmd, 8'($urandom), 8'($urandom));
                burst--; count--;
            end
            idle_input($urandom_range(1, 4));
        end
    endtask

    initial begin
        drive_sb = new();
        drive_sb.reset_state();
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: stick extremes, centre, diagonals, ticks
        send_word(1, 8'd0, 8'd0);
        send_word(0, 0, 0);
        send_word(1, 8'd127, 8'd0);
        send_word(1, 8'h80, 8'd0);
        send_word(1, 8'd0, 8'd127);
        send_word(1, 8'd0, 8'h80);
        send_word(1, 8'h80, 8'h80);
        send_word(1, 8'd127, 8'd127);
        send_word(1, 8'h80, 8'd127);
        send_word(1, 8'd127, 8'h80);
        send_word(1, 8'd5, 8'hFB);
        send_word(1, 8'd3, 8'd4);
        send_word(1, 8'hFD, 8'hFC);
        repeat (6) send_word(0, 0, 0);
        s_tvalid <= 0;
        drain();
        // extremes: zero full scale, min duty above 100, short period, a write to the undefined index
        write_reg(jddp_pkg::REG_FULL_SCALE, 16'd0);
        write_reg(jddp_pkg::REG_MIN_DUTY, 16'd127);
        write_reg(jddp_pkg::REG_PERIOD, 16'd1);
        write_reg(REG_UNDEF, 16'hFFFF);
        send_word(1, 8'd20, 8'hE0);
        repeat (4) send_word(0, 0, 0);
        s_tvalid <= 0;
        drain();
        write_reg(jddp_pkg::REG_MIN_DUTY, 16'd0);
        write_reg(jddp_pkg::REG_PERIOD, 16'd120);
        random_traffic(200, 10);
        drain();
        write_reg(jddp_pkg::REG_FULL_SCALE, 16'd255);
        write_reg(jddp_pkg::REG_MIN_DUTY, 16'd100);
        write_reg(jddp_pkg::REG_PERIOD, 16'd65535);
        stall_on = 0;
        random_traffic(100, 10);
        drain();
        stall_on = 1;
        write_reg(jddp_pkg::REG_FULL_SCALE, 16'd1);
        write_reg(jddp_pkg::REG_MIN_DUTY, 16'd30);
        write_reg(jddp_pkg::REG_PERIOD, 16'd60);
        random_traffic(200, 12);
        drain();
        write_reg(jddp_pkg::REG_FULL_SCALE, 16'($urandom_range(1, 254)));
        write_reg(jddp_pkg::REG_MIN_DUTY, 16'($urandom_range(0, 100)));
        write_reg(jddp_pkg::REG_PERIOD, 16'($urandom_range(20, 150)));
        random_traffic(200, 10);
        drain();
        if (drive_sb.errors == 0) $display("CHECK OK");
        else $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: filelist.f
hw/rtl/jddp_pkg.sv
hw/rtl/jddp_root.sv
hw/rtl/jddp_duty.sv
hw/rtl/joystick_differential_drive_pwm.sv
dv/tb_joystick_differential_drive_pwm.sv
